// ----- rtl/core/masked_block_mean_rgb_top_assert.svh -----
// ----------------------------------------------------------------------------
// masked_block_mean_rgb_top assertion macros
// Shared assertion forms for the masked block mean core.
// ----------------------------------------------------------------------------
`ifndef MASKED_BLOCK_MEAN_RGB_TOP_ASSERT_SVH
`define MASKED_BLOCK_MEAN_RGB_TOP_ASSERT_SVH

// implication checked on every edge outside reset
`define MBM_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked on the next edge
`define MBM_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/mbm_pkg.sv -----
// ----------------------------------------------------------------------------
// mbm_pkg
// Shared constants and grid helpers of the masked block mean core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mbm_pkg;
	localparam int MaxBlocksAcross = 64;
	localparam int MaxBlockSize    = 64;
	localparam int SumW            = 20;
	localparam int CntW            = 13;
	localparam int DimW            = 13;
	localparam int MeanW           = 8;
	localparam logic [DimW-1:0] MaxDim = 13'd4096;

	localparam logic [2:0] RegBlockSize = 3'd0;
	localparam logic [2:0] RegRoiWidth  = 3'd1;
	localparam logic [2:0] RegRoiHeight = 3'd2;
	localparam logic [2:0] RegMinCount  = 3'd3;

	// block idx starting at base is part of the grid
	function automatic logic in_grid(logic [6:0] idx, logic [13:0] base, logic [6:0] bs,
			logic [DimW-1:0] dim, logic [6:0] cap);
		logic [13:0] end_pos;
		logic [13:0] rem;
		logic [15:0] rem4;
		end_pos = base + {7'd0, bs};
		rem     = {1'b0, dim} - base;
		rem4    = {rem, 2'b00};
		return (idx < cap) && (base < {1'b0, dim}) &&
			((end_pos <= {1'b0, dim}) || (rem4 > {9'd0, bs}));
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/mbm_div.sv -----
// ----------------------------------------------------------------------------
// mbm_div
// Three-lane restoring divider, one quotient bit per cycle, 8-bit quotients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mbm_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [mbm_pkg::SumW-1:0]      num_r,
	input  wire logic [mbm_pkg::SumW-1:0]      num_g,
	input  wire logic [mbm_pkg::SumW-1:0]      num_b,
	input  wire logic [mbm_pkg::CntW-1:0]      den,
	output logic                               done,
	output logic [mbm_pkg::MeanW-1:0]          q_r,
	output logic [mbm_pkg::MeanW-1:0]          q_g,
	output logic [mbm_pkg::MeanW-1:0]          q_b
);
	logic                        busy_q;
	logic [2:0]                  step_q;
	logic [mbm_pkg::SumW-1:0]    rem_r_q, rem_g_q, rem_b_q, dsh_q;
	logic                        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_r_q <= num_r;
			rem_g_q <= num_g;
			rem_b_q <= num_b;
			dsh_q   <= {den, 7'd0};
		end else if (busy_q) begin
			if (rem_r_q >= dsh_q) begin
				rem_r_q <= rem_r_q - dsh_q;
				q_r     <= {q_r[6:0], 1'b1};
			end else begin
				q_r <= {q_r[6:0], 1'b0};
			end
			if (rem_g_q >= dsh_q) begin
				rem_g_q <= rem_g_q - dsh_q;
				q_g     <= {q_g[6:0], 1'b1};
			end else begin
				q_g <= {q_g[6:0], 1'b0};
			end
			if (rem_b_q >= dsh_q) begin
				rem_b_q <= rem_b_q - dsh_q;
				q_b     <= {q_b[6:0], 1'b1};
			end else begin
				q_b <= {q_b[6:0], 1'b0};
			end
			dsh_q <= {1'b0, dsh_q[mbm_pkg::SumW-1:1]};
		end
	end

	assign done = done_q;
endmodule
`default_nettype wire

// ----- rtl/core/masked_block_mean_rgb_top.sv -----
// ----------------------------------------------------------------------------
// masked_block_mean_rgb_top
// Per-block masked RGB means over a raster region, emitted per block band.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per request (tdata = red, green, blue from bit 0,
//   tuser = masked). One pixel is taken per cycle while the core runs; a
//   pixel's sum lands in the column memory in the cycle after it is taken, with
//   forwarding between back-to-back pixels of the same block.
//   After the pixel that ends a band of block rows the input stalls while the
//   band drains: a flush state, then per block column a memory read, a load
//   state that starts the divider, the divide itself and an output state that
//   waits for m_axis_tready.
//   m_axis holds each result until tready; while it stalls nothing advances.
//   tlast marks the final block of a band, tuser[1] the final block of the
//   region.
//   cfg writes (index 0..3: block_size, roi_width, roi_height, min_count)
//   restart the region. Reset loads the default registers and clears all
//   counters and per-column entry valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "masked_block_mean_rgb_top_assert.svh"
module masked_block_mean_rgb_top #(
	parameter int MAX_BLOCKS_ACROSS = mbm_pkg::MaxBlocksAcross,
	parameter int MAX_BLOCK_SIZE    = mbm_pkg::MaxBlockSize
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // red, green, blue
	input  wire logic        s_axis_tuser,  // masked
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // block_col, block_row, mean_red, mean_green,
	                                        // mean_blue, zero pad
	output logic             m_axis_tlast,  // last_in_band
	output logic [1:0]       m_axis_tuser   // valid_res, last_in_frame
);
	localparam int AW = (MAX_BLOCKS_ACROSS > 1) ? $clog2(MAX_BLOCKS_ACROSS) : 1;
	localparam int EW = 3 * mbm_pkg::SumW + mbm_pkg::CntW;
	localparam logic [6:0] Cap   = 7'(MAX_BLOCKS_ACROSS);
	localparam logic [6:0] MaxBs = 7'(MAX_BLOCK_SIZE);

	typedef enum logic [2:0] {ST_RUN, ST_FLUSH, ST_RD, ST_LOAD, ST_DIV, ST_OUT} state_t;

	state_t state_q;
	logic [6:0]  bs_q;
	logic [12:0] w_q, h_q, minc_q;
	logic [6:0]  bs_e;
	logic [12:0] w_e, h_e;

	logic [11:0] col_q, row_q;
	logic [5:0]  cib_q, brc_q;
	logic [6:0]  bc_q, br_q;
	logic [12:0] cbase_q, rbase_q;

	logic [EW-1:0] mem [MAX_BLOCKS_ACROSS];
	logic [MAX_BLOCKS_ACROSS-1:0] ent_vld_q;
	logic [EW-1:0] rd_q;
	logic          ent_s1;

	logic          wr_s1, fwd_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    r_s1, g_s1, b_s1;
	logic [EW-1:0] fwd_data_s1, old_s1, new_s1;

	logic [6:0]  k_q;
	logic [13:0] kbase_q;
	logic [5:0]  band_br_q;
	logic        band_last_q;

	logic        div_start, div_done;
	logic [7:0]  qr, qg, qb;
	logic [mbm_pkg::CntW-1:0] n_q;
	logic        ok_q;

	logic [5:0]  o_col_q, o_row_q;
	logic [7:0]  o_r_q, o_g_q, o_b_q;
	logic        o_vld_q, o_lb_q, o_lf_q, m_valid_q;

	logic in_acc, cfg_acc, col_in, row_in, col_end, last_row, band_end, masked;
	logic nxt_k_in;

	always_comb begin
		bs_e = (bs_q == 7'd0) ? 7'd1 : ((bs_q > MaxBs) ? MaxBs : bs_q);
		w_e  = (w_q == 13'd0) ? 13'd1 : ((w_q > mbm_pkg::MaxDim) ? mbm_pkg::MaxDim : w_q);
		h_e  = (h_q == 13'd0) ? 13'd1 : ((h_q > mbm_pkg::MaxDim) ? mbm_pkg::MaxDim : h_q);
	end

	assign cfg_ready     = 1'b1;
	assign cfg_acc       = cfg_valid && cfg_ready;
	assign s_axis_tready = (state_q == ST_RUN);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign masked        = s_axis_tuser;

	assign col_in   = mbm_pkg::in_grid(bc_q, {1'b0, cbase_q}, bs_e, w_e, Cap);
	assign row_in   = mbm_pkg::in_grid(br_q, {1'b0, rbase_q}, bs_e, h_e, Cap);
	assign col_end  = ({1'b0, col_q} + 13'd1) >= w_e;
	assign last_row = ({1'b0, row_q} + 13'd1) >= h_e;
	assign band_end = (({1'b0, brc_q} + 7'd1) >= bs_e) || last_row;
	assign nxt_k_in = mbm_pkg::in_grid(k_q + 7'd1, kbase_q + {7'd0, bs_e}, bs_e, w_e, Cap);

	// position counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q    <= 7'd8;
			w_q     <= 13'd640;
			h_q     <= 13'd480;
			minc_q  <= 13'd32;
			col_q   <= '0;
			row_q   <= '0;
			cib_q   <= '0;
			brc_q   <= '0;
			bc_q    <= '0;
			br_q    <= '0;
			cbase_q <= '0;
			rbase_q <= '0;
		end else if (cfg_acc) begin
			unique case (cfg_index)
				mbm_pkg::RegBlockSize: bs_q   <= cfg_data[6:0];
				mbm_pkg::RegRoiWidth:  w_q    <= cfg_data;
				mbm_pkg::RegRoiHeight: h_q    <= cfg_data;
				mbm_pkg::RegMinCount:  minc_q <= cfg_data;
				default: ;
			endcase
			if (cfg_index <= mbm_pkg::RegMinCount) begin
				col_q   <= '0;
				row_q   <= '0;
				cib_q   <= '0;
				brc_q   <= '0;
				bc_q    <= '0;
				br_q    <= '0;
				cbase_q <= '0;
				rbase_q <= '0;
			end
		end else if (in_acc) begin
			if (col_end) begin
				col_q   <= '0;
				cib_q   <= '0;
				bc_q    <= '0;
				cbase_q <= '0;
				if (last_row) begin
					row_q   <= '0;
					brc_q   <= '0;
					br_q    <= '0;
					rbase_q <= '0;
				end else begin
					row_q <= row_q + 12'd1;
					if (band_end) begin
						brc_q   <= '0;
						br_q    <= (br_q == 7'd64) ? br_q : br_q + 7'd1;
						rbase_q <= rbase_q + {6'd0, bs_e};
					end else begin
						brc_q <= brc_q + 6'd1;
					end
				end
			end else begin
				col_q <= col_q + 12'd1;
				if (({1'b0, cib_q} + 7'd1) >= bs_e) begin
					cib_q   <= '0;
					bc_q    <= (bc_q == 7'd64) ? bc_q : bc_q + 7'd1;
					cbase_q <= cbase_q + {6'd0, bs_e};
				end else begin
					cib_q <= cib_q + 6'd1;
				end
			end
		end
	end

	// column memory: read on accept or drain, written in the cycle after an accept
	always_comb begin
		old_s1 = fwd_s1 ? fwd_data_s1 : (ent_s1 ? rd_q : '0);
		new_s1[19:0]  = old_s1[19:0]  + {12'd0, r_s1};
		new_s1[39:20] = old_s1[39:20] + {12'd0, g_s1};
		new_s1[59:40] = old_s1[59:40] + {12'd0, b_s1};
		new_s1[72:60] = old_s1[72:60] + 13'd1;
	end

	always_ff @(posedge clk) begin
		if (wr_s1) begin
			mem[addr_s1] <= new_s1;
		end
		if (in_acc) begin
			rd_q        <= mem[bc_q[AW-1:0]];
			ent_s1      <= ent_vld_q[bc_q[AW-1:0]];
			addr_s1     <= bc_q[AW-1:0];
			fwd_s1      <= wr_s1 && (addr_s1 == bc_q[AW-1:0]);
			fwd_data_s1 <= new_s1;
			r_s1        <= s_axis_tdata[7:0];
			g_s1        <= s_axis_tdata[15:8];
			b_s1        <= s_axis_tdata[23:16];
		end else if (state_q == ST_RD) begin
			rd_q   <= mem[k_q[AW-1:0]];
			ent_s1 <= ent_vld_q[k_q[AW-1:0]];
		end
	end

	// drain sequencer
	assign div_start = (state_q == ST_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			wr_s1       <= 1'b0;
			ent_vld_q   <= '0;
			m_valid_q   <= 1'b0;
			k_q         <= '0;
			kbase_q     <= '0;
			band_br_q   <= '0;
			band_last_q <= 1'b0;
			n_q         <= '0;
			ok_q        <= 1'b0;
			o_col_q     <= '0;
			o_row_q     <= '0;
			o_r_q       <= '0;
			o_g_q       <= '0;
			o_b_q       <= '0;
			o_vld_q     <= 1'b0;
			o_lb_q      <= 1'b0;
			o_lf_q      <= 1'b0;
		end else begin
			wr_s1 <= in_acc && !masked && col_in && row_in;
			if (cfg_acc && (cfg_index <= mbm_pkg::RegMinCount)) begin
				ent_vld_q <= '0;
			end else if (wr_s1) begin
				ent_vld_q[addr_s1] <= 1'b1;
			end
			unique case (state_q)
				ST_RUN: begin
					if (in_acc && col_end && band_end && row_in) begin
						state_q     <= ST_FLUSH;
						band_br_q   <= br_q[5:0];
						band_last_q <= !mbm_pkg::in_grid(br_q + 7'd1,
							{1'b0, rbase_q} + {7'd0, bs_e}, bs_e, h_e, Cap);
						k_q         <= '0;
						kbase_q     <= '0;
					end
				end
				ST_FLUSH: begin
					if (mbm_pkg::in_grid(7'd0, 14'd0, bs_e, w_e, Cap)) begin
						state_q <= ST_RD;
					end else begin
						state_q   <= ST_RUN;
						ent_vld_q <= '0;
					end
				end
				ST_RD: state_q <= ST_LOAD;
				ST_LOAD: begin
					n_q     <= ent_s1 ? rd_q[72:60] : '0;
					ok_q    <= (ent_s1 ? rd_q[72:60] : 13'd0) >= minc_q;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						o_col_q   <= k_q[5:0];
						o_row_q   <= band_br_q;
						o_vld_q   <= ok_q;
						o_r_q     <= (ok_q && n_q != '0) ? qr : '0;
						o_g_q     <= (ok_q && n_q != '0) ? qg : '0;
						o_b_q     <= (ok_q && n_q != '0) ? qb : '0;
						o_lb_q    <= !nxt_k_in;
						o_lf_q    <= !nxt_k_in && band_last_q;
						m_valid_q <= 1'b1;
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						m_valid_q <= 1'b0;
						if (o_lb_q) begin
							state_q   <= ST_RUN;
							ent_vld_q <= '0;
						end else begin
							k_q     <= k_q + 7'd1;
							kbase_q <= kbase_q + {7'd0, bs_e};
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	mbm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_r  (ent_s1 ? rd_q[19:0]  : 20'd0),
		.num_g  (ent_s1 ? rd_q[39:20] : 20'd0),
		.num_b  (ent_s1 ? rd_q[59:40] : 20'd0),
		.den    (ent_s1 ? rd_q[72:60] : 13'd0),
		.done   (div_done),
		.q_r    (qr),
		.q_g    (qg),
		.q_b    (qb)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'd0, o_b_q, o_g_q, o_r_q, o_row_q, o_col_q};
	assign m_axis_tlast  = o_lb_q;
	assign m_axis_tuser  = {o_lf_q, o_vld_q};

	`MBM_ASSERT_IMP(a_no_in_while_out, clk, arst_n, m_axis_tvalid, !s_axis_tready, "input taken during drain")
	`MBM_ASSERT_IMP(a_div_in_drain, clk, arst_n, div_done, state_q == ST_DIV, "divider done outside drain")
	`MBM_ASSERT_IMP(a_frame_in_band, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast, "frame end not band end")
	`MBM_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
endmodule
`default_nettype wire
